>>> hdl/rle_block_decompressor_defines.svh
// ---------------------------------------------------------------------------
// RLE block decompressor assertion macros
// Shared concurrent assertion templates for the decompressor top level.
// ---------------------------------------------------------------------------
`ifndef RLE_BLOCK_DECOMPRESSOR_DEFINES_SVH
`define RLE_BLOCK_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rle_block_decompressor: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rle_block_decompressor: next-cycle check failed");

`endif

>>> hdl/rbd_pkg.sv
// ---------------------------------------------------------------------------
// RLE block decompressor package
// Types, codes and constants shared by the decompressor modules.
// ---------------------------------------------------------------------------
package rbd_pkg;

  // Header tags, little-endian byte order as they arrive
  localparam logic [31:0] TAG_COMPRESSED = 32'h4870_6D43;  // "CmpH"
  localparam logic [31:0] TAG_RAW        = 32'h4863_4E75;  // "uNcH"

  // Bit of a key word that marks a literal run
  localparam int unsigned LITERAL_BIT = 15;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HEADER,
    PH_KEY_LO,
    PH_KEY_HI,
    PH_REPEAT,
    PH_LITERAL,
    PH_RAW,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_TAG = 2'd1,
    ST_CLIPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  run_value;
    logic [14:0] run_count;
    status_t     status;
    logic        last;
    logic [31:0] total_bytes;
  } rbd_result_t;

endpackage

>>> hdl/rbd_if.sv
// ---------------------------------------------------------------------------
// RLE block decompressor channels
// Valid/ready interfaces for the byte input and the run output.
// ---------------------------------------------------------------------------
interface rbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       block_start;

  modport source (output valid, output in_byte, output block_start, input ready);
  modport sink   (input valid, input in_byte, input block_start, output ready);
endinterface

interface rbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  run_value;
  logic [14:0] run_count;
  logic [1:0]  status;
  logic        last;
  logic [31:0] total_bytes;

  modport source (output valid, output run_value, output run_count, output status,
                  output last, output total_bytes, input ready);
  modport sink   (input valid, input run_value, input run_count, input status,
                  input last, input total_bytes, output ready);
endinterface

>>> hdl/rbd_parser.sv
// ---------------------------------------------------------------------------
// RLE block decompressor parser
// Byte-serial header and key parser; one decision per accepted word.
// ---------------------------------------------------------------------------
module rbd_parser
  import rbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  logic        block_start,
  input  logic        stage_ready,
  output logic        res_valid,
  output rbd_result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] full_size_r, full_size_nxt;
  logic [31:0] produced_r, produced_nxt;
  logic [15:0] key_r, key_nxt;
  logic [14:0] lit_left_r, lit_left_nxt;

  logic        accept;
  phase_t      eff_phase;
  logic [2:0]  eff_hdr_cnt;
  logic [31:0] eff_tag, eff_full, eff_prod;
  logic [15:0] eff_key;
  logic [14:0] eff_lit;

  logic        hdr_done;
  logic [31:0] full_fin;
  logic        size_zero;
  logic [15:0] key_full;
  logic [31:0] remaining;
  logic [31:0] rep_cnt_ext;
  logic        rep_clip;
  logic        rep_last;
  logic [14:0] rep_count;
  logic        unit_last;
  logic [14:0] lit_dec;
  logic [31:0] prod_inc;

  assign accept = in_valid && stage_ready;

  // Apply block start: the word is parsed against a freshly cleared state
  always_comb begin
    if (block_start) begin
      eff_phase   = PH_HEADER;
      eff_hdr_cnt = '0;
      eff_tag     = '0;
      eff_full    = '0;
      eff_prod    = '0;
      eff_key     = '0;
      eff_lit     = '0;
    end else begin
      eff_phase   = phase_r;
      eff_hdr_cnt = hdr_cnt_r;
      eff_tag     = tag_r;
      eff_full    = full_size_r;
      eff_prod    = produced_r;
      eff_key     = key_r;
      eff_lit     = lit_left_r;
    end
  end

  // Shared decode terms
  always_comb begin
    hdr_done    = (eff_hdr_cnt == 3'd7);
    full_fin    = {in_byte, eff_full[23:0]};
    size_zero   = (full_fin == '0);
    key_full    = {in_byte, eff_key[7:0]};
    remaining   = eff_full - eff_prod;
    rep_cnt_ext = {17'd0, eff_key[14:0]};
    rep_clip    = (rep_cnt_ext > remaining);
    rep_last    = (rep_cnt_ext >= remaining);
    rep_count   = rep_clip ? remaining[14:0] : eff_key[14:0];
    unit_last   = (remaining == 32'd1);
    lit_dec     = eff_lit - 15'd1;
    prod_inc    = eff_prod + 32'd1;
  end

  // Next phase
  always_comb begin
    phase_nxt = eff_phase;
    unique case (eff_phase)
      PH_HEADER: begin
        if (hdr_done) begin
          if (eff_tag == TAG_COMPRESSED) begin
            phase_nxt = size_zero ? PH_DONE : PH_KEY_LO;
          end else if (eff_tag == TAG_RAW) begin
            phase_nxt = size_zero ? PH_DONE : PH_RAW;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end
      end
      PH_KEY_LO: phase_nxt = PH_KEY_HI;
      PH_KEY_HI: begin
        if (key_full[LITERAL_BIT]) begin
          phase_nxt = (key_full[14:0] != '0) ? PH_LITERAL : PH_KEY_LO;
        end else begin
          phase_nxt = (key_full != '0) ? PH_REPEAT : PH_KEY_LO;
        end
      end
      PH_REPEAT: phase_nxt = rep_last ? PH_DONE : PH_KEY_LO;
      PH_LITERAL: begin
        if (unit_last) begin
          phase_nxt = PH_DONE;
        end else if (lit_dec == '0) begin
          phase_nxt = PH_KEY_LO;
        end else begin
          phase_nxt = PH_LITERAL;
        end
      end
      PH_RAW: phase_nxt = unit_last ? PH_DONE : PH_RAW;
      default: phase_nxt = eff_phase;
    endcase
  end

  // Datapath updates and result word
  always_comb begin
    hdr_cnt_nxt   = eff_hdr_cnt;
    tag_nxt       = eff_tag;
    full_size_nxt = eff_full;
    produced_nxt  = eff_prod;
    key_nxt       = eff_key;
    lit_left_nxt  = eff_lit;
    res_valid     = 1'b0;
    res.run_value   = in_byte;
    res.run_count   = 15'd1;
    res.status      = ST_OK;
    res.last        = 1'b0;
    res.total_bytes = prod_inc;
    unique case (eff_phase)
      PH_HEADER: begin
        hdr_cnt_nxt = eff_hdr_cnt + 3'd1;
        if (!eff_hdr_cnt[2]) begin
          tag_nxt[8*eff_hdr_cnt[1:0] +: 8] = eff_tag[8*eff_hdr_cnt[1:0] +: 8] | in_byte;
        end else begin
          full_size_nxt[8*eff_hdr_cnt[1:0] +: 8] =
            eff_full[8*eff_hdr_cnt[1:0] +: 8] | in_byte;
        end
        res.run_value   = '0;
        res.run_count   = '0;
        res.last        = 1'b1;
        res.total_bytes = '0;
        if (hdr_done) begin
          if ((eff_tag != TAG_COMPRESSED) && (eff_tag != TAG_RAW)) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_TAG;
          end else if (size_zero) begin
            res_valid  = 1'b1;
          end
        end
      end
      PH_KEY_LO: key_nxt = {8'd0, in_byte};
      PH_KEY_HI: begin
        key_nxt = key_full;
        if (key_full[LITERAL_BIT]) begin
          lit_left_nxt = key_full[14:0];
        end
      end
      PH_REPEAT: begin
        produced_nxt    = rep_clip ? eff_full : (eff_prod + rep_cnt_ext);
        res_valid       = 1'b1;
        res.run_count   = rep_count;
        res.status      = rep_clip ? ST_CLIPPED : ST_OK;
        res.last        = rep_last;
        res.total_bytes = produced_nxt;
      end
      PH_LITERAL: begin
        lit_left_nxt = lit_dec;
        produced_nxt = prod_inc;
        res_valid    = 1'b1;
        res.status   = (unit_last && (lit_dec != '0)) ? ST_CLIPPED : ST_OK;
        res.last     = unit_last;
      end
      PH_RAW: begin
        produced_nxt = prod_inc;
        res_valid    = 1'b1;
        res.last     = unit_last;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    res_valid = res_valid && accept;
  end

  // Advance parse state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hdr_cnt_r   <= '0;
      tag_r       <= '0;
      full_size_r <= '0;
      produced_r  <= '0;
      key_r       <= '0;
      lit_left_r  <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      tag_r       <= tag_nxt;
      full_size_r <= full_size_nxt;
      produced_r  <= produced_nxt;
      key_r       <= key_nxt;
      lit_left_r  <= lit_left_nxt;
    end
  end

endmodule

>>> hdl/rbd_out_reg.sv
// ---------------------------------------------------------------------------
// RLE block decompressor output register
// Result register with a skid entry so the parser runs while the sink stalls.
// ---------------------------------------------------------------------------
module rbd_out_reg
  import rbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  input  rbd_result_t push_data,
  output logic        push_ready,
  output logic        out_valid,
  output rbd_result_t out_data,
  input  logic        out_ready
);

  logic        main_valid_r;
  rbd_result_t main_r;
  logic        skid_valid_r;
  rbd_result_t skid_r;
  logic        pop;

  assign push_ready = !skid_valid_r;
  assign pop        = main_valid_r && out_ready;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;

  // Hold a stalled word in the skid entry, drain it first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push_valid) begin
      if (!main_valid_r || pop) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push_valid) begin
      if (!main_valid_r || pop) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

endmodule

>>> hdl/rle_block_decompressor.sv
// ---------------------------------------------------------------------------
// RLE block decompressor
// Parses a stored block byte by byte and emits (value, count) runs.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one byte of the stored block per word; block_start marks
//   the first header byte and abandons any block in progress. The header is
//   a 4-byte tag and a little-endian 32-bit full size. A compressed tag
//   yields runs from 16-bit keys, a raw tag one run of one per byte, an
//   unknown tag one status word with status 1.
//   out_ch carries one run word per result; a downstream counter expands it.
//   A run is registered when the byte that ends it is accepted. Throughput:
//   one byte per cycle while in_ch.ready is high, set by the single parse
//   step between the parse-state registers and the output register.
//   Reset (rst_n low, synchronous) returns the parser to waiting for a block
//   start and empties the output register.
//   When the receiver stalls, one more word is taken into a skid entry and
//   then in_ch.ready drops until the word in the output register is taken.
// ---------------------------------------------------------------------------
`include "rle_block_decompressor_defines.svh"

module rle_block_decompressor
  import rbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  rbd_in_if.sink  in_ch,
  rbd_out_if.source out_ch
);

  logic        res_valid;
  rbd_result_t res;
  logic        stage_ready;
  logic        out_valid;
  rbd_result_t out_data;

  rbd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_byte     (in_ch.in_byte),
    .block_start (in_ch.block_start),
    .stage_ready (stage_ready),
    .res_valid   (res_valid),
    .res         (res)
  );

  rbd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (stage_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ch.ready)
  );

  // Drive the channels
  assign in_ch.ready        = stage_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.run_value   = out_data.run_value;
  assign out_ch.run_count   = out_data.run_count;
  assign out_ch.status      = out_data.status;
  assign out_ch.last        = out_data.last;
  assign out_ch.total_bytes = out_data.total_bytes;

  // A bad tag word is an empty, final word
  `RBD_ASSERT_IMPLY(a_bad_tag_empty, clk, rst_n,
    out_valid && (out_data.status == ST_BAD_TAG),
    out_data.last && (out_data.run_count == '0) && (out_data.total_bytes == '0))

  // A clipped run always ends the block
  `RBD_ASSERT_IMPLY(a_clip_is_last, clk, rst_n,
    out_valid && (out_data.status == ST_CLIPPED), out_data.last)

  // Only the final word of a block may carry an empty run
  `RBD_ASSERT_IMPLY(a_mid_run_nonzero, clk, rst_n,
    out_valid && !out_data.last, out_data.run_count != '0)

  // A stall with a full output register leaves the skid entry occupied
  `RBD_ASSERT_NEXT(a_skid_fill, clk, rst_n,
    res_valid && stage_ready && out_valid && !out_ch.ready, !stage_ready)

endmodule
